>>> hdl/assert_macros.svh
// Assertion macros shared by the calendar clock RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Check an implication in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/ccut_pkg.sv
// Package for the calendar clock: constants, command/status types, calendar functions.
// Depends on nothing.
package ccut_pkg;
	localparam int unsigned MaxYear = 2099;
	localparam logic [11:0] EPOCH_YEAR = 12'd1970;
	localparam logic [11:0] MAX_YEAR_C = 12'(MaxYear);
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_SETCAL = 2'd1;
	localparam logic [1:0] KIND_SETUNIX = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	// Days from 1970-01-01 to the first day after MaxYear, and the same in seconds.
	localparam longint unsigned UnixLimitDays = 64'(MaxYear - 1969) * 64'd365 +
		64'(MaxYear / 4 - 492) - 64'(MaxYear / 100 - 19) + 64'(MaxYear / 400 - 4);
	localparam longint unsigned UnixLimitSecs = UnixLimitDays * 64'd86400;
	localparam logic [31:0] UNIX_LIMIT_C = 32'(UnixLimitSecs);

	// Command from controller to datapath.
	typedef struct packed {
		logic load;      // capture input item
		logic tick;      // advance one second
		logic cal_check; // check calendar set, begin epoch accumulation
		logic yr_step;   // add/subtract one year span
		logic mo_step;   // add/subtract one month span
		logic tod_step;  // split time of day one step
		logic commit;    // write state and result
		logic reject;    // result with unchanged state
	} ccut_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic cal_ok;
		logic yr_done;
		logic mo_done;
		logic tod_done;
		logic unix_ok;
	} ccut_sts_t;

	// Leap rule over 1901..2199: every fourth year, except 2100.
	function automatic logic is_leap(input logic [11:0] y);
		begin
			is_leap = (y[1:0] == 2'd0) && (y != 12'd2100);
		end
	endfunction

	function automatic logic [4:0] days_in(input logic [11:0] y, input logic [3:0] m);
		begin
			case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days_in = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11: days_in = 5'd30;
				4'd2: days_in = is_leap(y) ? 5'd29 : 5'd28;
				default: days_in = 5'd0;
			endcase
		end
	endfunction

	// Reduce 0..63 modulo 7 by compare and subtract.
	function automatic logic [2:0] mod7(input logic [5:0] v);
		logic [5:0] r;
		begin
			r = v;
			if (r >= 6'd56) r = r - 6'd56;
			if (r >= 6'd28) r = r - 6'd28;
			if (r >= 6'd14) r = r - 6'd14;
			if (r >= 6'd7) r = r - 6'd7;
			mod7 = r[2:0];
		end
	endfunction
endpackage

>>> hdl/ccut_ctrl.sv
// Controller state machine for the calendar clock.
// Depends on ccut_pkg.
module ccut_ctrl import ccut_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [1:0] kind,
	input  logic      out_stall,
	output logic      out_valid,
	output ccut_cmd_t cmd,
	input  ccut_sts_t sts
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CAL  = 7'b0000010,
		S_YR   = 7'b0000100,
		S_MO   = 7'b0001000,
		S_TOD  = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   kind_cal_q, kind_unix_q, ok_q;
	logic   take;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign take      = in_valid && (state_q == S_IDLE);

	// Sequence the steps of one item.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (kind == KIND_TICK) state_d = S_FIN;
					else if (kind == KIND_SETCAL) state_d = S_CAL;
					else if (kind == KIND_SETUNIX) state_d = S_YR;
					else state_d = S_FIN;
				end
			end
			S_CAL: begin
				cmd.cal_check = 1'b1;
				state_d = sts.cal_ok ? S_YR : S_FIN;
			end
			S_YR: begin
				cmd.yr_step = 1'b1;
				if (kind_unix_q && !sts.unix_ok) state_d = S_FIN;
				else if (sts.yr_done) state_d = S_MO;
			end
			S_MO: begin
				cmd.mo_step = 1'b1;
				if (sts.mo_done) state_d = S_TOD;
			end
			S_TOD: begin
				cmd.tod_step = 1'b1;
				if (sts.tod_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (ok_q) cmd.commit = 1'b1;
				else cmd.reject = 1'b1;
				if (!(kind_cal_q || kind_unix_q) && ok_q) cmd.tick = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Register the state, item kind and outcome.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_cal_q <= 1'b0;
			kind_unix_q <= 1'b0;
			ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				kind_cal_q <= (kind == KIND_SETCAL);
				kind_unix_q <= (kind == KIND_SETUNIX);
				ok_q <= (kind != KIND_NONE);
			end else if (state_q == S_CAL && !sts.cal_ok) begin
				ok_q <= 1'b0;
			end else if (state_q == S_YR && kind_unix_q && !sts.unix_ok) begin
				ok_q <= 1'b0;
			end
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`ASSERT_IMPL(a_cmd_excl, clk, arst_n, 1'b1, !(cmd.commit && cmd.reject))
	`ASSERT_NEXT(a_fin_out, clk, arst_n, state_q == S_FIN, out_valid)
endmodule

>>> hdl/ccut_dp.sv
// Datapath for the calendar clock: state registers, year/month walk, time-of-day split.
// Depends on ccut_pkg.
module ccut_dp import ccut_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ccut_cmd_t   cmd,
	output ccut_sts_t   sts,
	input  logic [1:0]  kind,
	input  logic [11:0] set_year,
	input  logic [3:0]  set_month,
	input  logic [4:0]  set_day,
	input  logic [4:0]  set_hour,
	input  logic [5:0]  set_minute,
	input  logic [5:0]  set_second,
	input  logic [31:0] set_epoch_seconds,
	output logic        accepted,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [2:0]  weekday,
	output logic [31:0] epoch_seconds
);
	// Captured item.
	logic        unix_q;
	logic [11:0] sy_q;
	logic [3:0]  sm_q;
	logic [4:0]  sd_q, sh_q;
	logic [5:0]  smi_q, ss_q;
	logic [31:0] t_q;
	// Walk registers.
	logic [11:0] wy_q;
	logic [3:0]  wm_q;
	logic [16:0] days_q;   // days counted before target (unix set)
	logic [31:0] rem_q;    // seconds remaining (unix set)
	logic [4:0]  wh_q;
	logic [5:0]  wmi_q;
	logic [2:0]  wd_q;     // weekday walk
	logic [31:0] acc_q;    // epoch accumulation (cal set)
	// Clock state.
	logic [11:0] cy_q;
	logic [3:0]  cm_q;
	logic [4:0]  cd_q, ch_q;
	logic [5:0]  cmi_q, cs_q;
	logic [2:0]  cw_q;
	logic [31:0] ce_q;
	logic        acc_ok_q;

	logic        leap_w;
	logic [31:0] yspan, mspan;
	logic [4:0]  dim_w;
	logic [31:0] limit;
	logic [2:0]  wd_yr, wd_mo;

	assign limit  = UNIX_LIMIT_C;
	assign leap_w = is_leap(wy_q);
	assign yspan  = leap_w ? 32'd31622400 : 32'd31536000;
	assign dim_w  = days_in(wy_q, wm_q);
	assign mspan  = 32'(dim_w) * 32'(SECS_PER_DAY);
	// Weekday moves by 1 or 2 over a year, by days mod 7 over a month.
	assign wd_yr  = mod7(6'(wd_q) + (leap_w ? 6'd2 : 6'd1));
	assign wd_mo  = mod7(6'(wd_q) + 6'(dim_w - 5'd28));

	// Set checks, walk ends; calendar counts years below target, Unix subtracts spans.
	always_comb begin
		sts = '0;
		sts.cal_ok = (sm_q >= 4'd1) && (sm_q <= 4'd12) && (sh_q <= 5'd23) &&
			(smi_q <= 6'd59) && (ss_q <= 6'd59) && (sy_q >= EPOCH_YEAR) &&
			(sy_q <= MAX_YEAR_C) && (sd_q >= 5'd1) && (sd_q <= days_in(sy_q, sm_q));
		sts.unix_ok = (t_q < limit);
		sts.yr_done = unix_q ? (rem_q < yspan) : (wy_q == sy_q);
		sts.mo_done = unix_q ? ((rem_q < mspan) || (wm_q >= 4'd12)) : (wm_q == sm_q);
		sts.tod_done = unix_q ? (rem_q < 32'(SECS_PER_DAY)) && (rem_q < 32'd3600) &&
			(rem_q < 32'd60) : 1'b1;
	end

	// Clock tick logic.
	logic [11:0] ty;
	logic [3:0]  tm;
	logic [4:0]  td, th;
	logic [5:0]  tmi, ts;
	logic [2:0]  tw;
	logic [31:0] te;
	logic        twrap;
	always_comb begin
		ty = cy_q; tm = cm_q; td = cd_q; th = ch_q; tmi = cmi_q; ts = cs_q; tw = cw_q;
		te = ce_q + 32'd1;
		twrap = 1'b0;
		if (cs_q != 6'd59) ts = cs_q + 6'd1;
		else begin
			ts = '0;
			if (cmi_q != 6'd59) tmi = cmi_q + 6'd1;
			else begin
				tmi = '0;
				if (ch_q != 5'd23) th = ch_q + 5'd1;
				else begin
					th = '0;
					tw = (cw_q == 3'd6) ? 3'd0 : cw_q + 3'd1;
					if (cd_q < days_in(cy_q, cm_q)) td = cd_q + 5'd1;
					else begin
						td = 5'd1;
						if (cm_q < 4'd12) tm = cm_q + 4'd1;
						else begin
							tm = 4'd1;
							if (cy_q >= MAX_YEAR_C) twrap = 1'b1;
							else ty = cy_q + 12'd1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			unix_q <= (kind == KIND_SETUNIX);
			sy_q <= set_year; sm_q <= set_month; sd_q <= set_day;
			sh_q <= set_hour; smi_q <= set_minute; ss_q <= set_second;
			t_q <= set_epoch_seconds;
			rem_q <= set_epoch_seconds;
			wy_q <= EPOCH_YEAR; wm_q <= 4'd1; wd_q <= 3'd4;
			days_q <= '0; wh_q <= '0; wmi_q <= '0;
		end
		if (cmd.cal_check) begin
			acc_q <= 32'(sh_q) * 32'd3600 + 32'(smi_q) * 32'd60 + 32'(ss_q);
		end
		if (cmd.yr_step && !sts.yr_done) begin
			wy_q <= wy_q + 12'd1;
			wd_q <= wd_yr;
			if (unix_q) rem_q <= rem_q - yspan;
			else acc_q <= acc_q + yspan;
		end
		if (cmd.mo_step && !sts.mo_done) begin
			wm_q <= wm_q + 4'd1;
			wd_q <= wd_mo;
			if (unix_q) rem_q <= rem_q - mspan;
			else acc_q <= acc_q + mspan;
		end
		if (cmd.mo_step && sts.mo_done && !unix_q) begin
			acc_q <= acc_q + 32'(sd_q - 5'd1) * 32'(SECS_PER_DAY);
			wd_q <= mod7(6'(wd_q) + 6'(sd_q - 5'd1));
		end
		// Split remaining seconds: days, then hours, then minutes.
		if (cmd.tod_step && !sts.tod_done) begin
			if (rem_q >= 32'(SECS_PER_DAY)) begin
				rem_q <= rem_q - 32'(SECS_PER_DAY);
				days_q <= days_q + 17'd1;
				wd_q <= (wd_q == 3'd6) ? 3'd0 : wd_q + 3'd1;
			end else if (rem_q >= 32'd3600) begin
				rem_q <= rem_q - 32'd3600;
				wh_q <= wh_q + 5'd1;
			end else begin
				rem_q <= rem_q - 32'd60;
				wmi_q <= wmi_q + 6'd1;
			end
		end
	end

	// Commit state and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cy_q <= EPOCH_YEAR; cm_q <= 4'd1; cd_q <= 5'd1; ch_q <= '0;
			cmi_q <= '0; cs_q <= '0; cw_q <= 3'd4; ce_q <= '0; acc_ok_q <= 1'b0;
		end else begin
			if (cmd.reject) acc_ok_q <= 1'b0;
			if (cmd.commit) begin
				acc_ok_q <= 1'b1;
				if (cmd.tick) begin
					if (twrap) begin
						cy_q <= EPOCH_YEAR; cm_q <= 4'd1; cd_q <= 5'd1; ch_q <= '0;
						cmi_q <= '0; cs_q <= '0; cw_q <= 3'd4; ce_q <= '0;
					end else begin
						cy_q <= ty; cm_q <= tm; cd_q <= td; ch_q <= th;
						cmi_q <= tmi; cs_q <= ts; cw_q <= tw; ce_q <= te;
					end
				end else if (unix_q) begin
					cy_q <= wy_q; cm_q <= wm_q; cd_q <= 5'(days_q) + 5'd1;
					ch_q <= wh_q; cmi_q <= wmi_q; cs_q <= rem_q[5:0];
					cw_q <= wd_q; ce_q <= t_q;
				end else begin
					cy_q <= sy_q; cm_q <= sm_q; cd_q <= sd_q; ch_q <= sh_q;
					cmi_q <= smi_q; cs_q <= ss_q; cw_q <= wd_q; ce_q <= acc_q;
				end
			end
		end
	end

	assign accepted = acc_ok_q;
	assign year = cy_q; assign month = cm_q; assign day = cd_q; assign hour = ch_q;
	assign minute = cmi_q; assign second = cs_q; assign weekday = cw_q;
	assign epoch_seconds = ce_q;

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_month_rng, clk, arst_n, 1'b1, cm_q >= 4'd1 && cm_q <= 4'd12)
	`ASSERT_IMPL(a_wd_rng, clk, arst_n, 1'b1, cw_q <= 3'd6)
	`ASSERT_NEXT(a_rej_hold, clk, arst_n, cmd.reject, $stable(ce_q) && $stable(cy_q))
endmodule

>>> hdl/calendar_clock_with_unix_time_top.sv
// Top level of the calendar clock with Unix seconds count.
// Depends on ccut_pkg, ccut_ctrl, ccut_dp.
//
// Usage:
//  Input channel in_valid/in_stall carries one command: kind 0 advances one
//  second, kind 1 sets calendar fields, kind 2 sets from Unix seconds.
//  Output channel out_valid/out_stall returns one result per command: the
//  accepted flag and the full clock state after the command.
//  A tick passes the finish state only; a rejected set ends at the field check
//  or the Unix range check. A calendar set checks the fields, then walks one
//  year per cycle from 1970 and one month per cycle. A Unix set walks years
//  and months, then splits days, hours and minutes one per cycle.
//  One command is in work at a time; in_stall is high until the result is
//  taken, and the next command transfers in the cycle after at the earliest.
//  While out_stall is high the result holds.
//  Reset sets 1970-01-01 00:00:00, Thursday, Unix seconds 0.
module calendar_clock_with_unix_time_top import ccut_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [11:0] set_year,
	input  logic [3:0]  set_month,
	input  logic [4:0]  set_day,
	input  logic [4:0]  set_hour,
	input  logic [5:0]  set_minute,
	input  logic [5:0]  set_second,
	input  logic [31:0] set_epoch_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [2:0]  weekday,
	output logic [31:0] epoch_seconds
);
	ccut_cmd_t cmd;
	ccut_sts_t sts;

	ccut_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .out_stall, .out_valid,
		.cmd, .sts
	);

	ccut_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .kind, .set_year, .set_month, .set_day,
		.set_hour, .set_minute, .set_second, .set_epoch_seconds, .accepted,
		.year, .month, .day, .hour, .minute, .second, .weekday, .epoch_seconds
	);
endmodule

>>> test/calendar_clock_with_unix_time_top_tb.sv
// Self-checking testbench for the calendar clock with Unix seconds count.
// Depends on ccut_pkg and calendar_clock_with_unix_time_top; keeps its own clock model.
`timescale 1ns / 100ps

module calendar_clock_with_unix_time_top_tb import ccut_pkg::*;;

	localparam int unsigned TopYear = MaxYear;
	localparam longint unsigned UnixLimit = UnixLimitSecs;

	typedef struct {
		logic        ok;
		logic [11:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		logic [4:0]  hr;
		logic [5:0]  mi;
		logic [5:0]  se;
		logic [2:0]  wd;
		logic [31:0] ep;
	} clock_view_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [11:0] set_year;
	logic [3:0]  set_month;
	logic [4:0]  set_day;
	logic [4:0]  set_hour;
	logic [5:0]  set_minute;
	logic [5:0]  set_second;
	logic [31:0] set_epoch_seconds;
	logic        out_valid;
	logic        out_stall;
	logic        accepted;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [2:0]  weekday;
	logic [31:0] epoch_seconds;

	// Model state of the clock
	int unsigned m_year, m_month, m_day, m_hour, m_minute, m_second, m_weekday;
	logic [31:0] m_epoch;

	clock_view_t pending_views[$];
	int          fail_count;
	int          hold_request;
	bit          tx_idle_on;
	bit          rx_idle_on;

	calendar_clock_with_unix_time_top u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic bit year_has_feb29(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(int unsigned y, int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11: return 30;
			2: return year_has_feb29(y) ? 29 : 28;
			default: return 0;
		endcase
	endfunction

	function automatic longint unsigned days_from_epoch(int unsigned y, int unsigned m,
			int unsigned d);
		longint unsigned n;
		n = 0;
		for (int unsigned i = 1970; i < y; i++) n += year_has_feb29(i) ? 366 : 365;
		for (int unsigned i = 1; i < m && i <= 12; i++) n += month_length(y, i);
		if (d >= 1) n += d - 1;
		return n;
	endfunction

	function automatic void clock_to_epoch_start();
		m_year = 1970; m_month = 1; m_day = 1;
		m_hour = 0; m_minute = 0; m_second = 0;
		m_weekday = 4; m_epoch = 0;
	endfunction

	// Advance one second with carries through the calendar
	function automatic void clock_advance();
		m_epoch = m_epoch + 32'd1;
		if (++m_second < 60) return;
		m_second = 0;
		if (++m_minute < 60) return;
		m_minute = 0;
		if (++m_hour < 24) return;
		m_hour = 0;
		m_weekday = (m_weekday + 1) % 7;
		if (++m_day <= month_length(m_year, m_month)) return;
		m_day = 1;
		if (++m_month <= 12) return;
		m_month = 1;
		if (++m_year > TopYear) clock_to_epoch_start();
	endfunction

	function automatic bit clock_set_calendar(int unsigned y, int unsigned mo,
			int unsigned d, int unsigned h, int unsigned mi, int unsigned s);
		longint unsigned days;
		if (mo < 1 || mo > 12 || h > 23 || mi > 59 || s > 59) return 0;
		if (y < 1970 || y > TopYear) return 0;
		if (d < 1 || d > month_length(y, mo)) return 0;
		days = days_from_epoch(y, mo, d);
		m_year = y; m_month = mo; m_day = d;
		m_hour = h; m_minute = mi; m_second = s;
		m_weekday = 32'((days + 4) % 7);
		m_epoch = 32'(days * 86400 + h * 3600 + mi * 60 + s);
		return 1;
	endfunction

	function automatic bit clock_set_unix(longint unsigned t);
		longint unsigned rem, span;
		int unsigned y, m, sod;
		if (t >= UnixLimit) return 0;
		rem = t; y = 1970; m = 1;
		forever begin
			span = (year_has_feb29(y) ? 366 : 365) * 64'd86400;
			if (rem < span) break;
			rem -= span;
			y++;
		end
		forever begin
			span = month_length(y, m) * 64'd86400;
			if (rem < span || m >= 12) break;
			rem -= span;
			m++;
		end
		m_year = y; m_month = m;
		m_day = 32'(rem / 86400 + 1);
		sod = 32'(rem % 86400);
		m_hour = sod / 3600;
		m_minute = (sod % 3600) / 60;
		m_second = sod % 60;
		m_weekday = 32'((t / 86400 + 4) % 7);
		m_epoch = t[31:0];
		return 1;
	endfunction

	// Apply one command to the model and queue the view it leaves
	function automatic void predict_clock_view();
		clock_view_t v;
		bit ok;
		ok = 0;
		case (kind)
			KIND_TICK: begin
				clock_advance();
				ok = 1;
			end
			KIND_SETCAL: ok = clock_set_calendar(set_year, set_month, set_day,
					set_hour, set_minute, set_second);
			KIND_SETUNIX: ok = clock_set_unix(set_epoch_seconds);
			default: ok = 0;
		endcase
		v.ok = ok; v.yr = 12'(m_year); v.mo = 4'(m_month); v.dy = 5'(m_day);
		v.hr = 5'(m_hour); v.mi = 6'(m_minute); v.se = 6'(m_second);
		v.wd = 3'(m_weekday); v.ep = m_epoch;
		pending_views.push_back(v);
	endfunction

	// Offer one command and hold it until the transfer
	task automatic send_command(logic [1:0] k, int unsigned y, int unsigned mo,
			int unsigned d, int unsigned h, int unsigned mi, int unsigned s,
			logic [31:0] t);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= k;
		set_year <= 12'(y);
		set_month <= 4'(mo);
		set_day <= 5'(d);
		set_hour <= 5'(h);
		set_minute <= 6'(mi);
		set_second <= 6'(s);
		set_epoch_seconds <= t;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_clock_view();
	endtask

	task automatic send_tick();
		send_command(KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);
	endtask

	task automatic send_calendar(int unsigned y, int unsigned mo, int unsigned d,
			int unsigned h, int unsigned mi, int unsigned s);
		send_command(KIND_SETCAL, y, mo, d, h, mi, s, $urandom);
	endtask

	task automatic send_unix(logic [31:0] t);
		send_command(KIND_SETUNIX, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, t);
	endtask

	// Drive the result stall: random holds, or a long one on request
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
			end else begin
				n = rx_idle_on ? $urandom_range(0, 16) : 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic report_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
		end
	endtask

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		clock_view_t v;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_views.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, expected none, got epoch %0d", $realtime,
						epoch_seconds);
			end else begin
				v = pending_views.pop_front();
				report_field("accepted", v.ok, accepted);
				report_field("year", v.yr, year);
				report_field("month", v.mo, month);
				report_field("day", v.dy, day);
				report_field("hour", v.hr, hour);
				report_field("minute", v.mi, minute);
				report_field("second", v.se, second);
				report_field("weekday", v.wd, weekday);
				report_field("epoch_seconds", v.ep, epoch_seconds);
			end
		end
	end

	task automatic test_ticks_from_reset();
		repeat (3) send_tick();
	endtask

	task automatic test_calendar_set();
		send_calendar(1970, 1, 1, 0, 0, 0);
		send_calendar(2000, 2, 29, 12, 30, 30);
		send_calendar(2001, 2, 29, 0, 0, 0);
		send_calendar(2024, 4, 31, 0, 0, 0);
		send_calendar(2024, 0, 1, 0, 0, 0);
		send_calendar(2024, 15, 1, 0, 0, 0);
		send_calendar(2024, 5, 0, 0, 0, 0);
		send_calendar(2024, 5, 31, 31, 0, 0);
		send_calendar(2024, 5, 1, 24, 63, 63);
		send_calendar(2024, 5, 1, 0, 60, 0);
		send_calendar(2024, 5, 1, 0, 0, 60);
		send_calendar(1969, 12, 31, 23, 59, 59);
		send_calendar(4095, 12, 31, 23, 59, 59);
		send_command(KIND_NONE, 2024, 5, 1, 0, 0, 0, 32'd0);
		send_calendar(2024, 2, 28, 23, 59, 59);
		send_tick();
	endtask

	task automatic test_unix_set();
		send_unix(32'd0);
		send_unix(32'd4102444799);
		send_unix(32'd4102444800);
		send_unix(32'hFFFF_FFFF);
		send_unix(32'h7FFF_FFFF);
	endtask

	task automatic test_end_of_range();
		send_calendar(TopYear, 12, 31, 23, 59, 59);
		send_tick();
		send_tick();
	endtask

	// Keep offering while the result side holds off for a long stretch
	task automatic test_backpressure();
		hold_request = 600;
		repeat (6) send_tick();
	endtask

	task automatic test_random_mix(int items);
		int sent, sel, y, mo, n;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 99) == 0) begin
				tx_idle_on = $urandom_range(0, 3) != 0;
				rx_idle_on = $urandom_range(0, 3) != 0;
			end
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				// boundary set followed by ticks across the carries
				y = $urandom_range(1970, TopYear);
				if ($urandom_range(0, 9) == 0) y = TopYear;
				mo = $urandom_range(1, 12);
				send_calendar(y, mo, $urandom_range(0, 3) == 0 ? $urandom_range(1, 31) :
						month_length(y, mo), 23, 59, $urandom_range(55, 59));
				n = $urandom_range(1, 6);
				repeat (n) send_tick();
				sent += n + 1;
			end else if (sel < 7) begin
				send_calendar($urandom_range(0, 4095), $urandom_range(0, 15),
						$urandom_range(0, 31), $urandom_range(0, 31),
						$urandom_range(0, 63), $urandom_range(0, 63));
				sent++;
			end else if (sel < 9) begin
				send_unix($urandom_range(0, 3) == 0 ? $urandom : 32'($urandom % UnixLimit));
				sent++;
			end else begin
				send_command(2'($urandom), $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom);
				sent++;
			end
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		set_year = '0;
		set_month = '0;
		set_day = '0;
		set_hour = '0;
		set_minute = '0;
		set_second = '0;
		set_epoch_seconds = '0;
		fail_count = 0;
		hold_request = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		clock_to_epoch_start();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ticks_from_reset();
		test_calendar_set();
		test_unix_set();
		test_end_of_range();
		test_backpressure();
		test_random_mix(1300);
		in_valid <= 1'b0;
		waited = 0;
		while (pending_views.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending_views.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

>>> files.f
+incdir+hdl
hdl/ccut_pkg.sv
hdl/ccut_ctrl.sv
hdl/ccut_dp.sv
hdl/calendar_clock_with_unix_time_top.sv
test/calendar_clock_with_unix_time_top_tb.sv
